// ----- hw/rtl/color_histogram_equalizer_defines.svh -----
// Assertion macros shared by the color histogram equalizer RTL.
// No dependencies; included by the modules that check their own logic.
`ifndef COLOR_HISTOGRAM_EQUALIZER_DEFINES_SVH
`define COLOR_HISTOGRAM_EQUALIZER_DEFINES_SVH

// Check that ante implies cons in the same cycle.
`define CHE_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that ante implies cons in the next cycle.
`define CHE_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/chist_pkg.sv -----
// Shared types, constants and fixed-point helpers for the histogram equalizer.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package chist_pkg;

	localparam int COUNT_WIDTH    = 22;
	localparam int COEF_FRAC_BITS = 16;
	localparam int BINS           = 256;
	localparam int BIN_W          = 8;
	localparam int SUM_W          = COEF_FRAC_BITS + 11;
	localparam int CDF_W          = COUNT_WIDTH + BIN_W;
	localparam int NUM_W          = CDF_W + 10;
	localparam int DEN_W          = COUNT_WIDTH + 1;
	localparam int REM_W          = DEN_W + BIN_W;

	localparam longint K_YR = ((longint'(299) << COEF_FRAC_BITS) + 500) / 1000;
	localparam longint K_YG = ((longint'(587) << COEF_FRAC_BITS) + 500) / 1000;
	localparam longint K_YB = ((longint'(114) << COEF_FRAC_BITS) + 500) / 1000;
	localparam longint K_UR = ((longint'(169) << COEF_FRAC_BITS) + 500) / 1000;
	localparam longint K_UG = ((longint'(331) << COEF_FRAC_BITS) + 500) / 1000;
	localparam longint K_UB = ((longint'(499) << COEF_FRAC_BITS) + 500) / 1000;
	localparam longint K_VR = ((longint'(499) << COEF_FRAC_BITS) + 500) / 1000;
	localparam longint K_VG = ((longint'(418) << COEF_FRAC_BITS) + 500) / 1000;
	localparam longint K_VB = ((longint'(813) << COEF_FRAC_BITS) + 5000) / 10000;
	localparam longint K_RV = ((longint'(1402) << COEF_FRAC_BITS) + 500) / 1000;
	localparam longint K_GU = ((longint'(344) << COEF_FRAC_BITS) + 500) / 1000;
	localparam longint K_GV = ((longint'(714) << COEF_FRAC_BITS) + 500) / 1000;
	localparam longint K_BU = ((longint'(1772) << COEF_FRAC_BITS) + 500) / 1000;
	localparam longint HALF_OFFSET = longint'(128) << COEF_FRAC_BITS;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_COUNT  = 2'd1,
		CMD_FINISH = 2'd2,
		CMD_EQUAL  = 2'd3
	} cmd_code_t;

	typedef enum logic [1:0] {
		MAP_IDENT,
		MAP_ZERO,
		MAP_SAT,
		MAP_QUO
	} map_src_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic     in_load;
		logic     idx_clr;
		logic     idx_inc;
		logic     total_clr;
		logic     total_inc;
		logic     hist_rd;
		logic     hist_rd_y;
		logic     hist_wr;
		logic     hist_wr_zero;
		logic     y_load;
		logic     scan_init;
		logic     scan_chk;
		logic     cdf_clr;
		logic     cdf_acc;
		logic     num_load;
		logic     div_start;
		logic     div_step;
		logic     map_wr;
		map_src_t map_src;
		logic     yuv_load;
		logic     eq_rd;
		logic     out_load;
	} dp_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic idx_last;
		logic den_zero;
		logic cdf_le;
		logic num_ge;
		logic div_last;
		logic out_free;
	} dp_sts_t;

	// Shift a Q-format sum down to a byte, clamping to 0..255
	function automatic logic [7:0] fix_to_byte(input logic signed [SUM_W-1:0] t);
		logic signed [SUM_W-1:0] sh;
		sh = t >>> COEF_FRAC_BITS;
		if (t < 0) begin
			return 8'd0;
		end else if (sh > SUM_W'(255)) begin
			return 8'd255;
		end else begin
			return sh[7:0];
		end
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/chist_ctrl.sv -----
// Sequencing state machine of the histogram equalizer.
// Depends on chist_pkg; drives dp_cmd_t to the datapath and reads dp_sts_t.
`default_nettype none
`include "color_histogram_equalizer_defines.svh"

module chist_ctrl
	import chist_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire logic [1:0] in_cmd,
	output dp_cmd_t        cmd,
	input  wire dp_sts_t   sts
);

	typedef enum logic [4:0] {
		ST_CLR, ST_IDLE,
		ST_C_Y, ST_C_RD, ST_C_WR,
		ST_F_S_RD, ST_F_S_CHK, ST_F_DEC, ST_F_ID,
		ST_F_B_RD, ST_F_B_ACC, ST_F_B_NUM, ST_F_B_CHK, ST_F_DIV, ST_F_WQ,
		ST_E_YUV, ST_E_RD, ST_E_OUT
	} state_t;

	state_t state_q;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// Decode commands from the current state
	always_comb begin
		cmd = '0;
		cmd.map_src = MAP_IDENT;
		case (state_q)
			ST_CLR: begin
				cmd.hist_wr      = 1'b1;
				cmd.hist_wr_zero = 1'b1;
				cmd.idx_inc      = 1'b1;
			end
			ST_IDLE: begin
				if (accept) begin
					cmd.in_load = 1'b1;
					cmd.idx_clr = 1'b1;
					cmd.total_clr = (cmd_code_t'(in_cmd) == CMD_CLEAR);
					cmd.scan_init = (cmd_code_t'(in_cmd) == CMD_FINISH);
				end
			end
			ST_C_Y:     cmd.y_load = 1'b1;
			ST_C_RD: begin
				cmd.hist_rd   = 1'b1;
				cmd.hist_rd_y = 1'b1;
			end
			ST_C_WR: begin
				cmd.hist_wr   = 1'b1;
				cmd.total_inc = 1'b1;
			end
			ST_F_S_RD:  cmd.hist_rd = 1'b1;
			ST_F_S_CHK: begin
				cmd.scan_chk = 1'b1;
				cmd.idx_inc  = 1'b1;
			end
			ST_F_DEC: begin
				cmd.idx_clr = 1'b1;
				cmd.cdf_clr = 1'b1;
			end
			ST_F_ID: begin
				cmd.map_wr  = 1'b1;
				cmd.map_src = MAP_IDENT;
				cmd.idx_inc = 1'b1;
			end
			ST_F_B_RD:  cmd.hist_rd = 1'b1;
			ST_F_B_ACC: cmd.cdf_acc = 1'b1;
			ST_F_B_NUM: cmd.num_load = 1'b1;
			ST_F_B_CHK: begin
				if (sts.cdf_le) begin
					cmd.map_wr  = 1'b1;
					cmd.map_src = MAP_ZERO;
					cmd.idx_inc = 1'b1;
				end else if (sts.num_ge) begin
					cmd.map_wr  = 1'b1;
					cmd.map_src = MAP_SAT;
					cmd.idx_inc = 1'b1;
				end else begin
					cmd.div_start = 1'b1;
				end
			end
			ST_F_DIV:   cmd.div_step = 1'b1;
			ST_F_WQ: begin
				cmd.map_wr  = 1'b1;
				cmd.map_src = MAP_QUO;
				cmd.idx_inc = 1'b1;
			end
			ST_E_YUV:   cmd.yuv_load = 1'b1;
			ST_E_RD:    cmd.eq_rd = 1'b1;
			ST_E_OUT:   cmd.out_load = sts.out_free;
			default: ;
		endcase
	end

	// Advance the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			case (state_q)
				ST_CLR:     if (sts.idx_last) state_q <= ST_IDLE;
				ST_IDLE: begin
					if (accept) begin
						case (cmd_code_t'(in_cmd))
							CMD_CLEAR:  state_q <= ST_CLR;
							CMD_COUNT:  state_q <= ST_C_Y;
							CMD_FINISH: state_q <= ST_F_S_RD;
							CMD_EQUAL:  state_q <= ST_E_YUV;
							default:    state_q <= ST_IDLE;
						endcase
					end
				end
				ST_C_Y:     state_q <= ST_C_RD;
				ST_C_RD:    state_q <= ST_C_WR;
				ST_C_WR:    state_q <= ST_IDLE;
				ST_F_S_RD:  state_q <= ST_F_S_CHK;
				ST_F_S_CHK: state_q <= sts.idx_last ? ST_F_DEC : ST_F_S_RD;
				ST_F_DEC:   state_q <= sts.den_zero ? ST_F_ID : ST_F_B_RD;
				ST_F_ID:    if (sts.idx_last) state_q <= ST_IDLE;
				ST_F_B_RD:  state_q <= ST_F_B_ACC;
				ST_F_B_ACC: state_q <= ST_F_B_NUM;
				ST_F_B_NUM: state_q <= ST_F_B_CHK;
				ST_F_B_CHK: begin
					if (sts.cdf_le || sts.num_ge) begin
						state_q <= sts.idx_last ? ST_IDLE : ST_F_B_RD;
					end else begin
						state_q <= ST_F_DIV;
					end
				end
				ST_F_DIV:   if (sts.div_last) state_q <= ST_F_WQ;
				ST_F_WQ:    state_q <= sts.idx_last ? ST_IDLE : ST_F_B_RD;
				ST_E_YUV:   state_q <= ST_E_RD;
				ST_E_RD:    state_q <= ST_E_OUT;
				ST_E_OUT:   if (sts.out_free) state_q <= ST_IDLE;
				default:    state_q <= ST_IDLE;
			endcase
		end
	end

	`CHE_ASSERT_NXT(a_one_item, accept, !in_ready, "ctrl took a beat while busy")

endmodule

`default_nettype wire

// ----- hw/rtl/chist_dp.sv -----
// Datapath of the histogram equalizer: histogram and map memories, color
// conversion, cdf accumulation and the map divider. Depends on chist_pkg.
`default_nettype none
`include "color_histogram_equalizer_defines.svh"

module chist_dp
	import chist_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire dp_cmd_t    cmd,
	output dp_sts_t         sts,
	input  wire logic [7:0] red_in,
	input  wire logic [7:0] green_in,
	input  wire logic [7:0] blue_in,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      red_out,
	output logic [7:0]      green_out,
	output logic [7:0]      blue_out
);

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	logic [COUNT_WIDTH-1:0] hist_mem [BINS];
	logic [7:0]             map_mem  [BINS];

	logic [7:0]             r_q, g_q, b_q, y_q, map_rd_q, quo_q;
	logic signed [9:0]      u_q, v_q;
	logic [BIN_W-1:0]       idx_q;
	logic [COUNT_WIDTH-1:0] hist_rd_q, total_q, cmin_q;
	logic                   found_q, le_q, out_valid_q;
	logic [CDF_W-1:0]       cdf_q;
	logic [NUM_W-1:0]       num_q;
	logic [REM_W-1:0]       rem_q;
	logic [2:0]             step_q;
	logic signed [SUM_W-1:0] prv_q, pgu_q, pgv_q, pbu_q;

	logic signed [9:0]      rs, gs, bs;
	logic signed [SUM_W-1:0] ysum, usum, vsum, ye;
	logic [COUNT_WIDTH-1:0] den;
	logic [DEN_W-1:0]       dd;
	logic [CDF_W-1:0]       numv;
	logic [NUM_W-1:0]       nwide;
	logic [REM_W-1:0]       trial;
	logic [BIN_W-1:0]       hist_raddr, hist_waddr;
	logic [COUNT_WIDTH-1:0] hist_wdata;
	logic [7:0]             map_wdata;
	logic [7:0]             ub, vb;

	function automatic logic signed [SUM_W-1:0] mulk(input logic signed [9:0] a,
		input longint k);
		return SUM_W'(a) * SUM_W'(k);
	endfunction

	// Color conversion from the latched pixel
	assign rs   = signed'({2'b00, r_q});
	assign gs   = signed'({2'b00, g_q});
	assign bs   = signed'({2'b00, b_q});
	assign ysum = mulk(rs, K_YR) + mulk(gs, K_YG) + mulk(bs, K_YB);
	assign usum = SUM_W'(HALF_OFFSET) + mulk(bs, K_UB) - mulk(rs, K_UR) - mulk(gs, K_UG);
	assign vsum = SUM_W'(HALF_OFFSET) + mulk(rs, K_VR) - mulk(gs, K_VG) - mulk(bs, K_VB);
	assign ub   = fix_to_byte(usum);
	assign vb   = fix_to_byte(vsum);
	assign ye   = signed'(SUM_W'(map_rd_q)) <<< COEF_FRAC_BITS;

	// Map arithmetic
	assign den   = total_q - cmin_q;
	assign dd    = {den, 1'b0};
	assign numv  = cdf_q - CDF_W'(cmin_q);
	assign nwide = (NUM_W'(numv) << 9) - (NUM_W'(numv) << 1) + NUM_W'(den);
	assign trial = REM_W'(dd) << step_q;

	assign sts.idx_last = (idx_q == BIN_W'(BINS - 1));
	assign sts.den_zero = (total_q <= cmin_q);
	assign sts.cdf_le   = le_q;
	assign sts.num_ge   = (num_q >= (NUM_W'(dd) << BIN_W));
	assign sts.div_last = (step_q == 3'd0);
	assign sts.out_free = !out_valid_q || out_ready;

	// Select memory addresses and write data
	assign hist_raddr = cmd.hist_rd_y ? y_q : idx_q;
	assign hist_waddr = cmd.hist_wr_zero ? idx_q : y_q;
	assign hist_wdata = cmd.hist_wr_zero ? '0 :
		((hist_rd_q == COUNT_MAX) ? hist_rd_q : hist_rd_q + 1'b1);

	always_comb begin
		case (cmd.map_src)
			MAP_IDENT: map_wdata = idx_q;
			MAP_ZERO:  map_wdata = 8'd0;
			MAP_SAT:   map_wdata = 8'd255;
			MAP_QUO:   map_wdata = quo_q;
			default:   map_wdata = 8'd0;
		endcase
	end

	// Histogram memory
	always_ff @(posedge clk) begin
		if (cmd.hist_wr) begin
			hist_mem[hist_waddr] <= hist_wdata;
		end
		if (cmd.hist_rd) begin
			hist_rd_q <= hist_mem[hist_raddr];
		end
	end

	// Luma map memory
	always_ff @(posedge clk) begin
		if (cmd.map_wr) begin
			map_mem[idx_q] <= map_wdata;
		end
		if (cmd.eq_rd) begin
			map_rd_q <= map_mem[y_q];
		end
	end

	// Hold pixel, conversion and divider payload
	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			r_q <= red_in;
			g_q <= green_in;
			b_q <= blue_in;
		end
		if (cmd.y_load || cmd.yuv_load) begin
			y_q <= fix_to_byte(ysum);
		end
		if (cmd.yuv_load) begin
			u_q <= signed'({2'b00, ub}) - 10'sd128;
			v_q <= signed'({2'b00, vb}) - 10'sd128;
		end
		if (cmd.eq_rd) begin
			prv_q <= mulk(v_q, K_RV);
			pgu_q <= mulk(u_q, K_GU);
			pgv_q <= mulk(v_q, K_GV);
			pbu_q <= mulk(u_q, K_BU);
		end
		if (cmd.cdf_clr) begin
			cdf_q <= '0;
		end else if (cmd.cdf_acc) begin
			cdf_q <= cdf_q + CDF_W'(hist_rd_q);
		end
		if (cmd.num_load) begin
			num_q <= nwide;
			le_q  <= (cdf_q <= CDF_W'(cmin_q));
		end
		if (cmd.div_start) begin
			rem_q  <= num_q[REM_W-1:0];
			quo_q  <= 8'd0;
			step_q <= 3'd7;
		end else if (cmd.div_step) begin
			if (rem_q >= trial) begin
				rem_q         <= rem_q - trial;
				quo_q[step_q] <= 1'b1;
			end
			step_q <= step_q - 3'd1;
		end
		if (cmd.out_load) begin
			red_out   <= fix_to_byte(ye + prv_q);
			green_out <= fix_to_byte(ye - pgu_q - pgv_q);
			blue_out  <= fix_to_byte(ye + pbu_q);
		end
	end

	// Control registers: bin index, pixel total, first cdf value, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			total_q     <= '0;
			cmin_q      <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.total_clr) begin
				total_q <= '0;
			end else if (cmd.total_inc && total_q != COUNT_MAX) begin
				total_q <= total_q + 1'b1;
			end
			if (cmd.scan_init) begin
				cmin_q  <= '0;
				found_q <= 1'b0;
			end else if (cmd.scan_chk && !found_q && hist_rd_q != '0) begin
				cmin_q  <= hist_rd_q;
				found_q <= 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`CHE_ASSERT_IMP(a_no_overwrite, cmd.out_load, !out_valid_q || out_ready,
		"output beat overwritten before it was taken")
	`CHE_ASSERT_IMP(a_hist_port, cmd.hist_wr, !cmd.hist_rd,
		"histogram read and write in the same cycle")
	`CHE_ASSERT_NXT(a_total_mono, !cmd.total_clr, total_q >= $past(total_q),
		"pixel total decreased without a clear")

endmodule

`default_nettype wire

// ----- hw/rtl/color_histogram_equalizer.sv -----
// Luma histogram equalizer, one item at a time. Count: luma, then bin read, then bin write.
// Equalize: YUV load, map read, then the result is registered once the output is free.
// Clear: one histogram bin written per cycle. Finish: the scan reads and checks each bin,
// then per bin a read, cdf add, numerator and check, plus 8 map divider steps if needed.
// Reset: asynchronous; then a histogram clearing pass over all 256 bins with s_tready low.
`default_nettype none

module color_histogram_equalizer
	import chist_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // cmd[1:0], red_in[9:2], green_in[17:10], blue_in[25:18]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata   // red_out[7:0], green_out[15:8], blue_out[23:16]
);

	dp_cmd_t    cmd;
	dp_sts_t    sts;
	logic [7:0] red_out, green_out, blue_out;

	chist_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_cmd   (s_tdata[1:0]),
		.cmd      (cmd),
		.sts      (sts)
	);

	chist_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.red_in    (s_tdata[9:2]),
		.green_in  (s_tdata[17:10]),
		.blue_in   (s_tdata[25:18]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out)
	);

	assign m_tdata = {blue_out, green_out, red_out};

endmodule

`default_nettype wire

// ----- tb/sv/tb_color_histogram_equalizer.sv -----
// Self-checking testbench for the luma histogram equalizer stream block.
// Depends on chist_pkg and color_histogram_equalizer; predicts each equalized pixel in place.
`default_nettype none

module tb_color_histogram_equalizer;
	import chist_pkg::*;

	localparam longint CNT_MAX   = (longint'(1) << COUNT_WIDTH) - 1;
	localparam longint CYCLE_CAP = 3000000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;

	// predictor state
	longint hist_bins [256];
	logic [7:0] luma_lut [256];
	longint pix_count;

	logic [23:0] pixel_fifo [$];
	int err_count = 0;
	longint cycle_count = 0;
	int send_idle_pct;
	int recv_idle_pct;
	bit hold_off;

	color_histogram_equalizer u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Cycle limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_CAP) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic logic [7:0] sat_byte(input longint t);
		longint sh;
		if (t < 0) return 8'd0;
		sh = t >>> COEF_FRAC_BITS;
		return (sh > 255) ? 8'd255 : sh[7:0];
	endfunction

	function automatic logic [7:0] luma(input longint r, input longint g, input longint b);
		return sat_byte(K_YR * r + K_YG * g + K_YB * b);
	endfunction

	function automatic void rebuild_lut();
		longint cdf, cmin, den, num, q;
		bit found;
		cdf = 0; cmin = 0; found = 0;
		for (int i = 0; i < 256; i++) begin
			if (!found && hist_bins[i] != 0) begin
				found = 1;
				cmin = hist_bins[i];
			end
		end
		if (pix_count <= cmin) begin
			for (int i = 0; i < 256; i++) luma_lut[i] = i[7:0];
			return;
		end
		den = pix_count - cmin;
		for (int i = 0; i < 256; i++) begin
			cdf += hist_bins[i];
			if (cdf <= cmin) begin
				luma_lut[i] = 8'd0;
			end else begin
				num = cdf - cmin;
				q = (2 * 255 * num + den) / (2 * den);
				luma_lut[i] = (q > 255) ? 8'd255 : q[7:0];
			end
		end
	endfunction

	// Advance the predictor by one accepted command
	function automatic void predict_pixel(input cmd_code_t cmd, input logic [7:0] r8,
			input logic [7:0] g8, input logic [7:0] b8);
		longint r, g, b, u, v, ye;
		logic [7:0] y;
		r = r8; g = g8; b = b8;
		case (cmd)
			CMD_CLEAR: begin
				for (int i = 0; i < 256; i++) hist_bins[i] = 0;
				pix_count = 0;
			end
			CMD_COUNT: begin
				y = luma(r, g, b);
				if (hist_bins[y] < CNT_MAX) hist_bins[y]++;
				if (pix_count < CNT_MAX) pix_count++;
			end
			CMD_FINISH: rebuild_lut();
			default: begin
				y = luma(r, g, b);
				u = longint'(sat_byte(HALF_OFFSET + K_UB * b - K_UR * r - K_UG * g)) - 128;
				v = longint'(sat_byte(HALF_OFFSET + K_VR * r - K_VG * g - K_VB * b)) - 128;
				ye = longint'(luma_lut[y]) << COEF_FRAC_BITS;
				pixel_fifo.push_back({sat_byte(ye + K_BU * u),
					sat_byte(ye - K_GU * u - K_GV * v), sat_byte(ye + K_RV * v)});
			end
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch %s at cycle %0d", msg, cycle_count);
		err_count++;
	endtask

	// Check each result beat against the oldest prediction
	always @(posedge clk) begin
		logic [23:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pixel_fifo.size() == 0) begin
				report_mismatch($sformatf("unexpected result beat %h", m_tdata));
			end else begin
				want = pixel_fifo.pop_front();
				if (m_tdata[7:0] != want[7:0])
					report_mismatch($sformatf("red: got %0d expected %0d",
						m_tdata[7:0], want[7:0]));
				if (m_tdata[15:8] != want[15:8])
					report_mismatch($sformatf("green: got %0d expected %0d",
						m_tdata[15:8], want[15:8]));
				if (m_tdata[23:16] != want[23:16])
					report_mismatch($sformatf("blue: got %0d expected %0d",
						m_tdata[23:16], want[23:16]));
			end
		end
	end

	// Receiver: random stall, or a long hold-off on request
	always @(negedge clk) begin
		if (hold_off)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Send one command beat, with random gaps before it; return at the accepting edge
	task automatic send_beat(input cmd_code_t cmd, input logic [7:0] r,
			input logic [7:0] g, input logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, b, g, r, cmd};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_pixel(cmd, r, g, b);
	endtask

	// Drop valid, then wait for every predicted result
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pixel_fifo.size() != 0) @(negedge clk);
	endtask

	task automatic send_random_pixel(input cmd_code_t cmd);
		send_beat(cmd, 8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)));
	endtask

	// Identity map: no pixels counted, and all pixels in one bin
	task automatic test_identity_map();
		send_beat(CMD_CLEAR, 8'd0, 8'd0, 8'd0);
		send_beat(CMD_FINISH, 8'd0, 8'd0, 8'd0);
		send_beat(CMD_EQUAL, 8'hff, 8'hff, 8'hff);
		send_beat(CMD_EQUAL, 8'h00, 8'h00, 8'h00);
		send_beat(CMD_EQUAL, 8'hff, 8'h00, 8'h00);
		send_beat(CMD_EQUAL, 8'h00, 8'hff, 8'h00);
		send_beat(CMD_EQUAL, 8'h00, 8'h00, 8'hff);
		send_beat(CMD_COUNT, 8'h40, 8'h40, 8'h40);
		send_beat(CMD_COUNT, 8'h40, 8'h40, 8'h40);
		send_beat(CMD_FINISH, 8'd0, 8'd0, 8'd0);
		send_beat(CMD_EQUAL, 8'h80, 8'h20, 8'hc0);
		wait_drained();
	endtask

	// Skewed histogram: bins below the first used bin map to zero
	task automatic test_clamped_low_bins();
		send_beat(CMD_CLEAR, 8'd0, 8'd0, 8'd0);
		send_beat(CMD_COUNT, 8'd100, 8'd100, 8'd100);
		send_beat(CMD_COUNT, 8'd200, 8'd200, 8'd200);
		send_beat(CMD_COUNT, 8'hff, 8'hff, 8'hff);
		send_beat(CMD_COUNT, 8'h00, 8'hff, 8'hff);
		send_beat(CMD_FINISH, 8'd0, 8'd0, 8'd0);
		send_beat(CMD_EQUAL, 8'd10, 8'd10, 8'd10);
		send_beat(CMD_EQUAL, 8'd150, 8'd150, 8'd150);
		send_beat(CMD_EQUAL, 8'hff, 8'hff, 8'hff);
		send_beat(CMD_EQUAL, 8'haa, 8'h55, 8'haa);
		wait_drained();
	endtask

	// Frames of random pixels: clear, count, finish, equalize; some noise mixed in
	task automatic test_random_frames(input int n_items);
		int sent;
		int n;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(9) == 0) begin
				send_random_pixel(cmd_code_t'($urandom_range(3)));
				sent++;
			end else begin
				send_beat(CMD_CLEAR, 8'd0, 8'd0, 8'd0);
				n = $urandom_range(40, 1);
				repeat (n) send_random_pixel(CMD_COUNT);
				send_beat(CMD_FINISH, 8'd0, 8'd0, 8'd0);
				repeat ($urandom_range(30, 1)) begin
					send_random_pixel(CMD_EQUAL);
					sent++;
				end
				sent += n + 2;
			end
		end
		wait_drained();
	endtask

	// Hold the receiver off while equalize beats keep coming
	task automatic test_output_backpressure();
		fork
			begin
				hold_off = 1'b1;
				repeat (300) @(negedge clk);
				hold_off = 1'b0;
			end
			repeat (20) send_random_pixel(CMD_EQUAL);
		join
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		hold_off = 1'b0;
		pix_count = 0;
		for (int i = 0; i < 256; i++) begin
			hist_bins[i] = 0;
			luma_lut[i] = 8'd0;
		end
		send_idle_pct = 36;
		recv_idle_pct = 49;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		test_identity_map();
		test_clamped_low_bins();
		test_output_backpressure();
		test_random_frames(220);
		send_idle_pct = 49;
		recv_idle_pct = 36;
		test_random_frames(200);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_frames(200);

		repeat (50) @(negedge clk);
		if (err_count == 0 && pixel_fifo.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/chist_pkg.sv
hw/rtl/chist_ctrl.sv
hw/rtl/chist_dp.sv
hw/rtl/color_histogram_equalizer.sv
tb/sv/tb_color_histogram_equalizer.sv
